// ===== design/device_dispatch_selector_unit_defines.svh =====
// Assertion macros for the checker of the dispatch selector.
`ifndef DEVICE_DISPATCH_SELECTOR_UNIT_DEFINES_SVH
`define DEVICE_DISPATCH_SELECTOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DDS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DDS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/dds_pkg.sv =====
// Shared constants, codes and structures of the device dispatch selector.
package dds_pkg;

  // Table depths and the length of the cell chain.
  localparam int MAX_DEVICES = 16;
  localparam int MAX_NODES   = 16;
  localparam int CHAIN_LEN   = (MAX_DEVICES > MAX_NODES) ? MAX_DEVICES : MAX_NODES;
  localparam int IDX_W       = (CHAIN_LEN > 1) ? $clog2(CHAIN_LEN) : 1;

  // Field widths.
  localparam int ACT_W   = 2;
  localparam int ENTRY_W = 4;
  localparam int CAT_W   = 3;
  localparam int PERF_W  = 16;
  localparam int LOAD_W  = 9;
  localparam int KIND_W  = 2;
  localparam int CNT_W   = 5;
  localparam int BONUS_W = 16;
  localparam int SCORE_W = 18;
  localparam int DEC_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int FRAC_W  = 8;
  localparam int ECO_W   = 7;

  // Width used to compare slot numbers against counts and indexes.
  localparam int CMP_A = (IDX_W > CNT_W) ? IDX_W : CNT_W;
  localparam int CMP_W = (CMP_A > ENTRY_W) ? CMP_A : ENTRY_W;

  // Cycles from a dispatch beat until every cell score is valid.
  localparam int SCORE_CYC = 2;
  localparam int SCNT_W    = (SCORE_CYC > 1) ? $clog2(SCORE_CYC) : 1;

  // Fixed-point constants.
  localparam logic [LOAD_W-1:0]  Q_ONE       = 9'd256;
  localparam logic [ECO_W-1:0]   ECO_PENALTY = 7'd77;
  localparam logic [LOAD_W-1:0]  THRESH_RST  = 9'd128;
  localparam logic [BONUS_W-1:0] BONUS_RST   = 16'd5120;

  // Input actions.
  localparam logic [ACT_W-1:0] ACT_DEV      = 2'd0;
  localparam logic [ACT_W-1:0] ACT_NODE     = 2'd1;
  localparam logic [ACT_W-1:0] ACT_DISPATCH = 2'd2;

  // Device categories.
  localparam logic [CAT_W-1:0] CAT_CPU = 3'd0;
  localparam logic [CAT_W-1:0] CAT_GPU = 3'd1;
  localparam logic [CAT_W-1:0] CAT_NPU = 3'd2;
  localparam logic [CAT_W-1:0] CAT_DSP = 3'd3;

  // Decisions.
  localparam logic [DEC_W-1:0] DEC_OFFLOAD = 2'd0;
  localparam logic [DEC_W-1:0] DEC_LOCAL   = 2'd1;
  localparam logic [DEC_W-1:0] DEC_NONE    = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BONUS        = 2'd3;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCORE,
    ST_START,
    ST_WALK,
    ST_DONE
  } state_t;

  // Table write broadcast to every cell.
  typedef struct packed {
    logic                dev_we;
    logic                node_we;
    logic [ENTRY_W-1:0]  index;
    logic [CAT_W-1:0]    category;
    logic [PERF_W-1:0]   perf;
    logic [LOAD_W-1:0]   load;
  } wr_t;

  // Dispatch status held for the whole selection.
  typedef struct packed {
    logic [CNT_W-1:0]    nd;
    logic [CNT_W-1:0]    nn;
    logic                use_node;
    logic [LOAD_W-1:0]   thresh;
    logic [LOAD_W-1:0]   thermal;
    logic                eco;
    logic                throttle;
    logic [KIND_W-1:0]   kind;
    logic [BONUS_W-1:0]  bonus;
  } disp_t;

  // Running selection passed from cell to cell.
  typedef struct packed {
    logic                vld;
    logic                node_any;
    logic [LOAD_W-1:0]   node_load;
    logic [IDX_W-1:0]    node_idx;
    logic                dev_have;
    logic [SCORE_W-1:0]  dev_score;
    logic [IDX_W-1:0]    dev_idx;
  } tok_t;

endpackage

// ===== design/dds_cell.sv =====
// One chain cell: a device and node slot, its score pipeline and the selection stage.
module dds_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [dds_pkg::IDX_W-1:0]   cell_idx,
  input  dds_pkg::wr_t                wr,
  input  dds_pkg::disp_t              disp,
  input  dds_pkg::tok_t               tok_in,
  output dds_pkg::tok_t               tok_out
);
  import dds_pkg::*;

  logic [CAT_W-1:0]          cat_r;
  logic [PERF_W-1:0]         perf_r;
  logic [LOAD_W-1:0]         load_r;
  logic [LOAD_W-1:0]         node_load_r;
  logic                      hit;
  logic                      dev_slot;
  logic                      node_slot;
  logic [LOAD_W-1:0]         avail;
  logic [PERF_W+LOAD_W-1:0]  p1_r;
  logic [PERF_W+2*LOAD_W-1:0] p2_full;
  logic [PERF_W-1:0]         base_r;
  logic [PERF_W+ECO_W-1:0]   eco_prod;
  logic [SCORE_W-1:0]        adj;
  logic                      bonus_hit;
  logic [SCORE_W-1:0]        score_r;
  logic                      dev_ok;
  logic                      node_ok;
  tok_t                      tok_nxt;
  tok_t                      tok_r;

  // Slot decode for table writes and for the active counts.
  assign hit       = CMP_W'(wr.index) == CMP_W'(cell_idx);
  assign dev_slot  = 32'(cell_idx) < MAX_DEVICES;
  assign node_slot = 32'(cell_idx) < MAX_NODES;
  assign dev_ok    = dev_slot && (CMP_W'(cell_idx) < CMP_W'(disp.nd));
  assign node_ok   = node_slot && (CMP_W'(cell_idx) < CMP_W'(disp.nn));

  // Table entries held in this cell.
  always_ff @(posedge clk) begin
    if (wr.dev_we && hit && dev_slot) begin
      cat_r  <= wr.category;
      perf_r <= wr.perf;
      load_r <= wr.load;
    end
    if (wr.node_we && hit && node_slot) begin
      node_load_r <= wr.load;
    end
  end

  // Available share of the device, with the load saturated at one.
  assign avail = (load_r > Q_ONE) ? '0 : Q_ONE - load_r;

  // Score pipeline: perf times availability, then times thermal factor.
  assign p2_full = p1_r * disp.thermal;

  always_ff @(posedge clk) begin
    p1_r   <= perf_r * avail;
    base_r <= p2_full[PERF_W+2*FRAC_W-1:2*FRAC_W];
  end

  // Governor adjustment and kind bonus.
  assign eco_prod  = base_r * ECO_PENALTY;
  assign bonus_hit = (disp.kind[0] && (cat_r == CAT_GPU)) ||
                     (disp.kind[1] && (cat_r == CAT_NPU));

  always_comb begin
    adj = SCORE_W'(base_r);
    if (disp.eco) begin
      if ((cat_r == CAT_NPU) || (cat_r == CAT_DSP)) begin
        adj = SCORE_W'({base_r, 1'b0});
      end else if ((cat_r == CAT_CPU) || (cat_r == CAT_GPU)) begin
        adj = SCORE_W'(eco_prod[PERF_W+ECO_W-1:FRAC_W]);
      end
    end else if (disp.throttle) begin
      adj = SCORE_W'(base_r >> 1);
    end
  end

  always_ff @(posedge clk) begin
    score_r <= adj + (bonus_hit ? SCORE_W'(disp.bonus) : '0);
  end

  // Selection stage: first least-loaded node and first strict maximum score.
  always_comb begin
    tok_nxt = tok_in;
    if (node_ok && (!tok_in.node_any || (node_load_r < tok_in.node_load))) begin
      tok_nxt.node_any  = 1'b1;
      tok_nxt.node_load = node_load_r;
      tok_nxt.node_idx  = cell_idx;
    end
    if (dev_ok && (!tok_in.dev_have || (score_r > tok_in.dev_score))) begin
      tok_nxt.dev_have  = 1'b1;
      tok_nxt.dev_score = score_r;
      tok_nxt.dev_idx   = cell_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

// ===== design/dds_ctrl.sv =====
// Sequencer of one dispatch and the result output register.
module dds_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          disp_go,
  input  dds_pkg::disp_t                disp,
  input  dds_pkg::tok_t                 tail,
  output logic                          idle,
  output logic                          head_vld,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [dds_pkg::DEC_W-1:0]     out_decision,
  output logic [dds_pkg::ENTRY_W-1:0]   out_target_index,
  output logic [dds_pkg::SCORE_W-1:0]   out_best_score
);
  import dds_pkg::*;

  state_t               state_r;
  state_t               state_nxt;
  logic [SCNT_W-1:0]    scnt_r;
  logic [SCNT_W-1:0]    scnt_nxt;
  logic                 res_load;
  logic                 out_load;
  logic [DEC_W-1:0]     dec_nxt;
  logic [ENTRY_W-1:0]   tgt_nxt;
  logic [SCORE_W-1:0]   best_nxt;
  logic [DEC_W-1:0]     res_dec_r;
  logic [ENTRY_W-1:0]   res_tgt_r;
  logic [SCORE_W-1:0]   res_best_r;
  logic                 out_valid_r;
  logic [DEC_W-1:0]     out_dec_r;
  logic [ENTRY_W-1:0]   out_tgt_r;
  logic [SCORE_W-1:0]   out_best_r;

  // Next state and strobes.
  always_comb begin
    state_nxt = state_r;
    scnt_nxt  = scnt_r;
    head_vld  = 1'b0;
    res_load  = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (disp_go) begin
          state_nxt = ST_SCORE;
          scnt_nxt  = '0;
        end
      end
      ST_SCORE: begin
        if (32'(scnt_r) == SCORE_CYC - 1) begin
          state_nxt = ST_START;
        end else begin
          scnt_nxt = scnt_r + 1'b1;
        end
      end
      ST_START: begin
        head_vld  = 1'b1;
        state_nxt = ST_WALK;
      end
      ST_WALK: begin
        if (tail.vld) begin
          res_load  = 1'b1;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      scnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      scnt_r  <= scnt_nxt;
    end
  end

  // Final decision from the selection that left the last cell.
  always_comb begin
    dec_nxt  = DEC_NONE;
    tgt_nxt  = '0;
    best_nxt = '0;
    if (disp.use_node && tail.node_any && (tail.node_load < disp.thresh)) begin
      dec_nxt = DEC_OFFLOAD;
      tgt_nxt = ENTRY_W'(tail.node_idx);
    end else if (disp.nd != '0) begin
      dec_nxt  = DEC_LOCAL;
      tgt_nxt  = ENTRY_W'(tail.dev_idx);
      best_nxt = tail.dev_score;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_dec_r  <= dec_nxt;
      res_tgt_r  <= tgt_nxt;
      res_best_r <= best_nxt;
    end
  end

  // Output register: holds a beat until it is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_dec_r  <= res_dec_r;
      out_tgt_r  <= res_tgt_r;
      out_best_r <= res_best_r;
    end
  end

  assign idle             = (state_r == ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_decision     = out_dec_r;
  assign out_target_index = out_tgt_r;
  assign out_best_score   = out_best_r;

endmodule

// ===== design/device_dispatch_selector_unit.sv =====
// Top level of the device dispatch selector: registers, cell chain and controller.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-----------------------------------------
//   in_     | input     | in_valid/in_ready  | action, slot, device entry, task status
//   out_    | output    | out_valid/out_ready| decision, target_index, best_score
//   cfg_    | input     | cfg_we             | cfg_index, cfg_data
//
// A dispatch runs the score pipeline in every cell, then the selection walks the cell
// chain one cell per cycle, then the result enters the output register.
// Reset is synchronous and clears the control state and the device and node counts;
// it sets the threshold and bonus registers to their reset values.
// A stalled result beat waits in the output register while table writes go on.
module device_dispatch_selector_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [dds_pkg::ACT_W-1:0]        in_action,
  input  logic [dds_pkg::ENTRY_W-1:0]      in_entry_index,
  input  logic [dds_pkg::CAT_W-1:0]        in_category,
  input  logic [dds_pkg::PERF_W-1:0]       in_perf_score,
  input  logic [dds_pkg::LOAD_W-1:0]       in_entry_load,
  input  logic                             in_task_critical,
  input  logic [dds_pkg::KIND_W-1:0]       in_model_kind,
  input  logic [dds_pkg::LOAD_W-1:0]       in_thermal_factor,
  input  logic                             in_overheating,
  input  logic                             in_eco_mode,
  input  logic                             in_power_throttle,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [dds_pkg::DEC_W-1:0]        out_decision,
  output logic [dds_pkg::ENTRY_W-1:0]      out_target_index,
  output logic [dds_pkg::SCORE_W-1:0]      out_best_score,
  input  logic                             cfg_we,
  input  logic [dds_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dds_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import dds_pkg::*;

  logic [CNT_W-1:0]    device_count_r;
  logic [CNT_W-1:0]    node_count_r;
  logic [LOAD_W-1:0]   threshold_r;
  logic [BONUS_W-1:0]  bonus_r;
  logic                accept;
  logic                disp_go;
  logic                idle;
  logic                head_vld;
  wr_t                 wr;
  disp_t               disp_nxt;
  disp_t               disp_r;
  tok_t                tok_w [CHAIN_LEN+1];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      device_count_r <= '0;
      node_count_r   <= '0;
      threshold_r    <= THRESH_RST;
      bonus_r        <= BONUS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEVICE_COUNT: device_count_r <= cfg_data[CNT_W-1:0];
        CFG_NODE_COUNT:   node_count_r   <= cfg_data[CNT_W-1:0];
        CFG_THRESHOLD:    threshold_r    <= cfg_data[LOAD_W-1:0];
        CFG_BONUS:        bonus_r        <= cfg_data[BONUS_W-1:0];
        default: ;
      endcase
    end
  end

  // Input beat decode.
  assign in_ready = idle;
  assign accept   = in_valid && in_ready;
  assign disp_go  = accept && (in_action == ACT_DISPATCH);

  assign wr.dev_we   = accept && (in_action == ACT_DEV);
  assign wr.node_we  = accept && (in_action == ACT_NODE);
  assign wr.index    = in_entry_index;
  assign wr.category = in_category;
  assign wr.perf     = in_perf_score;
  assign wr.load     = in_entry_load;

  // Dispatch status captured at the beat and held through the selection.
  always_comb begin
    disp_nxt.nd       = device_count_r;
    disp_nxt.nn       = node_count_r;
    disp_nxt.use_node = (node_count_r != '0) &&
                        (!in_task_critical || in_overheating || in_eco_mode);
    disp_nxt.thresh   = threshold_r;
    disp_nxt.thermal  = (in_thermal_factor > Q_ONE) ? Q_ONE : in_thermal_factor;
    disp_nxt.eco      = in_eco_mode;
    disp_nxt.throttle = in_power_throttle;
    disp_nxt.kind     = in_model_kind;
    disp_nxt.bonus    = bonus_r;
  end

  always_ff @(posedge clk) begin
    if (disp_go) begin
      disp_r <= disp_nxt;
    end
  end

  // Empty selection entering the head of the chain.
  always_comb begin
    tok_w[0]     = '0;
    tok_w[0].vld = head_vld;
  end

  // Cell chain.
  for (genvar i = 0; i < CHAIN_LEN; i++) begin : g_cell
    dds_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (IDX_W'(i)),
      .wr       (wr),
      .disp     (disp_r),
      .tok_in   (tok_w[i]),
      .tok_out  (tok_w[i+1])
    );
  end

  // Sequencer and output register.
  dds_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .disp_go          (disp_go),
    .disp             (disp_r),
    .tail             (tok_w[CHAIN_LEN]),
    .idle             (idle),
    .head_vld         (head_vld),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_decision     (out_decision),
    .out_target_index (out_target_index),
    .out_best_score   (out_best_score)
  );

endmodule

// ===== design/dds_checker.sv =====
// Port-level checker of the dispatch selector and its bind to the top level.
`include "device_dispatch_selector_unit_defines.svh"

module dds_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic [dds_pkg::ACT_W-1:0]        in_action,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [dds_pkg::DEC_W-1:0]        out_decision,
  input logic [dds_pkg::ENTRY_W-1:0]      out_target_index,
  input logic [dds_pkg::SCORE_W-1:0]      out_best_score
);
  import dds_pkg::*;

  // A stalled result beat holds its payload.
  `DDS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
    out_valid && $stable(out_decision) && $stable(out_target_index) &&
    $stable(out_best_score), "result beat changed while stalled")

  // Only a local decision carries a score.
  `DDS_ASSERT_IMP(a_score_local, clk, rst_n, out_valid && (out_decision != DEC_LOCAL),
    out_best_score == '0, "score given without a local decision")

  // No target means slot zero.
  `DDS_ASSERT_IMP(a_none_target, clk, rst_n, out_valid && (out_decision == DEC_NONE),
    out_target_index == '0, "target given without a decision")

  // A dispatch beat starts a selection that blocks the input.
  `DDS_ASSERT_NEXT(a_dispatch_busy, clk, rst_n,
    in_valid && in_ready && (in_action == ACT_DISPATCH), !in_ready,
    "input ready right after a dispatch beat")

endmodule

bind device_dispatch_selector_unit dds_checker u_dds_checker (.*);

// ===== dv/tb_device_dispatch_selector_unit.sv =====
// Testbench for the device dispatch selector: directed and random beats against a predictor.
`timescale 1ns / 1ps

module tb_device_dispatch_selector_unit;
  import dds_pkg::*;

  // Codes the package leaves unnamed.
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
  localparam logic [CAT_W-1:0] CAT_TOP    = 3'd7;

  // Margin waited after the last result before touching registers.
  localparam int DRAIN_CYCLES = 32;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 400;

  typedef struct {
    logic [ACT_W-1:0]   action;
    logic [ENTRY_W-1:0] entry;
    logic [CAT_W-1:0]   category;
    logic [PERF_W-1:0]  perf;
    logic [LOAD_W-1:0]  load;
    logic               critical;
    logic [KIND_W-1:0]  kind;
    logic [LOAD_W-1:0]  thermal;
    logic               hot;
    logic               eco;
    logic               throttle;
  } task_beat_t;

  typedef struct {
    logic [DEC_W-1:0]   decision;
    logic [ENTRY_W-1:0] target;
    logic [SCORE_W-1:0] score;
  } decision_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [ACT_W-1:0]      in_action;
  logic [ENTRY_W-1:0]    in_entry_index;
  logic [CAT_W-1:0]      in_category;
  logic [PERF_W-1:0]     in_perf_score;
  logic [LOAD_W-1:0]     in_entry_load;
  logic                  in_task_critical;
  logic [KIND_W-1:0]     in_model_kind;
  logic [LOAD_W-1:0]     in_thermal_factor;
  logic                  in_overheating;
  logic                  in_eco_mode;
  logic                  in_power_throttle;
  logic                  out_valid;
  logic                  out_ready;
  logic [DEC_W-1:0]      out_decision;
  logic [ENTRY_W-1:0]    out_target_index;
  logic [SCORE_W-1:0]    out_best_score;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Predictor copy of the tables and registers.
  logic [CAT_W-1:0]  cat_tbl       [MAX_DEVICES];
  logic [PERF_W-1:0] perf_tbl      [MAX_DEVICES];
  logic [LOAD_W-1:0] dev_load_tbl  [MAX_DEVICES];
  logic [LOAD_W-1:0] node_load_tbl [MAX_NODES];
  logic [CNT_W-1:0]  dev_cnt_reg;
  logic [CNT_W-1:0]  node_cnt_reg;
  logic [LOAD_W-1:0] thresh_reg;
  logic [BONUS_W-1:0] bonus_reg;

  decision_t expected_decisions[$];
  int        errors = 0;
  int        cycle_count = 0;
  int        hold_request = 0;
  logic      quiet = 1'b0;

  device_dispatch_selector_unit i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_action         (in_action),
    .in_entry_index    (in_entry_index),
    .in_category       (in_category),
    .in_perf_score     (in_perf_score),
    .in_entry_load     (in_entry_load),
    .in_task_critical  (in_task_critical),
    .in_model_kind     (in_model_kind),
    .in_thermal_factor (in_thermal_factor),
    .in_overheating    (in_overheating),
    .in_eco_mode       (in_eco_mode),
    .in_power_throttle (in_power_throttle),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_decision      (out_decision),
    .out_target_index  (out_target_index),
    .out_best_score    (out_best_score),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Local score of one device slot, in Q8.8, before truncation to the port width.
  function automatic logic [47:0] device_score(input int slot, input logic [LOAD_W-1:0] thermal,
                                               input logic eco, input logic throttle,
                                               input logic [KIND_W-1:0] kind);
    logic [LOAD_W-1:0] ld;
    logic [CAT_W-1:0]  cat;
    logic [47:0]       avail;
    logic [47:0]       s;
    cat   = cat_tbl[slot];
    ld    = (dev_load_tbl[slot] > Q_ONE) ? Q_ONE : dev_load_tbl[slot];
    avail = 48'(Q_ONE - ld);
    s     = (48'(perf_tbl[slot]) * avail * 48'(thermal)) >> 16;
    if (eco) begin
      if (cat == CAT_NPU || cat == CAT_DSP) s = s * 2;
      else if (cat == CAT_GPU || cat == CAT_CPU) s = (s * 48'(ECO_PENALTY)) >> 8;
    end else if (throttle) begin
      s = s >> 1;
    end
    // Affinity: vision models like GPUs, chat models like NPUs.
    if (kind[0] && cat == CAT_GPU) s = s + 48'(bonus_reg);
    if (kind[1] && cat == CAT_NPU) s = s + 48'(bonus_reg);
    return s;
  endfunction

  // Decision for one dispatch beat against the current tables.
  function automatic decision_t predict_dispatch(input task_beat_t b);
    decision_t         d;
    int                nn;
    int                nd;
    int                mi;
    logic [LOAD_W-1:0] thermal;
    logic [47:0]       s;
    logic [47:0]       best;
    logic              placed;
    d.decision = DEC_NONE;
    d.target   = '0;
    d.score    = '0;
    nn = (node_cnt_reg > MAX_NODES) ? MAX_NODES : int'(node_cnt_reg);
    nd = (dev_cnt_reg > MAX_DEVICES) ? MAX_DEVICES : int'(dev_cnt_reg);
    placed = 1'b0;
    // Offload to the first least-loaded node when it is under the threshold.
    if (nn > 0 && (!b.critical || b.hot || b.eco)) begin
      mi = 0;
      for (int i = 1; i < nn; i++)
        if (node_load_tbl[i] < node_load_tbl[mi]) mi = i;
      if (node_load_tbl[mi] < thresh_reg) begin
        d.decision = DEC_OFFLOAD;
        d.target   = ENTRY_W'(mi);
        placed     = 1'b1;
      end
    end
    // Otherwise the first device with the strictly highest score.
    if (!placed && nd > 0) begin
      thermal = (b.thermal > Q_ONE) ? Q_ONE : b.thermal;
      best = '0;
      for (int i = 0; i < nd; i++) begin
        s = device_score(i, thermal, b.eco, b.throttle, b.kind);
        if (i == 0 || s > best) begin
          best     = s;
          d.target = ENTRY_W'(i);
        end
      end
      d.decision = DEC_LOCAL;
      d.score    = best[SCORE_W-1:0];
    end
    return d;
  endfunction

  // Apply an accepted beat to the predictor.
  function automatic void record_beat(input task_beat_t b);
    case (b.action)
      ACT_DEV: begin
        cat_tbl[b.entry]      = b.category;
        perf_tbl[b.entry]     = b.perf;
        dev_load_tbl[b.entry] = b.load;
      end
      ACT_NODE: begin
        node_load_tbl[b.entry] = b.load;
      end
      ACT_DISPATCH: begin
        expected_decisions.push_back(predict_dispatch(b));
      end
      default: begin
        // The unused action is dropped without a result.
      end
    endcase
  endfunction

  function automatic task_beat_t rand_beat(input logic [ACT_W-1:0] action);
    task_beat_t b;
    b.action   = action;
    b.entry    = ENTRY_W'($urandom_range(0, 15));
    b.category = CAT_W'($urandom_range(0, 7));
    b.perf     = ($urandom_range(0, 7) == 0) ? 16'hFFFF : PERF_W'($urandom);
    b.load     = ($urandom_range(0, 3) == 0) ? LOAD_W'($urandom_range(0, 511))
                                             : LOAD_W'($urandom_range(0, 256));
    b.critical = 1'($urandom);
    b.kind     = KIND_W'($urandom);
    b.thermal  = LOAD_W'($urandom_range(0, 511));
    b.hot      = 1'($urandom);
    b.eco      = 1'($urandom);
    b.throttle = 1'($urandom);
    return b;
  endfunction

  // Random traffic mix: mostly dispatches, with table updates in between.
  function automatic task_beat_t rand_item();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 25) return rand_beat(ACT_DEV);
    if (pick < 40) return rand_beat(ACT_NODE);
    if (pick < 45) return rand_beat(ACT_UNUSED);
    return rand_beat(ACT_DISPATCH);
  endfunction

  function automatic logic [15:0] pick_count();
    case ($urandom_range(0, 4))
      0:       return 16'd0;
      1:       return 16'd1;
      2:       return 16'd16;
      3:       return (16'($urandom) & 16'hFFE0) | 16'd31;
      default: return 16'($urandom_range(0, 16));
    endcase
  endfunction

  function automatic logic [15:0] pick_thresh();
    case ($urandom_range(0, 3))
      0:       return 16'd0;
      1:       return 16'd256;
      2:       return 16'd511;
      default: return 16'($urandom_range(0, 511));
    endcase
  endfunction

  function automatic logic [15:0] pick_bonus();
    case ($urandom_range(0, 3))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Offer one beat on the input channel and wait until it is taken.
  task automatic send_beat(input task_beat_t b);
    int   gap;
    logic grant;
    gap = 0;
    if (!quiet && $urandom_range(0, 99) < 16) gap = $urandom_range(1, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_action         <= b.action;
    in_entry_index    <= b.entry;
    in_category       <= b.category;
    in_perf_score     <= b.perf;
    in_entry_load     <= b.load;
    in_task_critical  <= b.critical;
    in_model_kind     <= b.kind;
    in_thermal_factor <= b.thermal;
    in_overheating    <= b.hot;
    in_eco_mode       <= b.eco;
    in_power_throttle <= b.throttle;
    // Sample ready mid-cycle; nothing changes until the next edge.
    do begin
      @(negedge clk);
      grant = (in_ready === 1'b1);
      @(posedge clk);
    end while (!grant);
    record_beat(b);
  endtask

  task automatic send_device(input int slot, input logic [CAT_W-1:0] cat,
                             input logic [PERF_W-1:0] perf, input logic [LOAD_W-1:0] load);
    task_beat_t b;
    b          = rand_beat(ACT_DEV);
    b.entry    = ENTRY_W'(slot);
    b.category = cat;
    b.perf     = perf;
    b.load     = load;
    send_beat(b);
  endtask

  task automatic send_node(input int slot, input logic [LOAD_W-1:0] load);
    task_beat_t b;
    b       = rand_beat(ACT_NODE);
    b.entry = ENTRY_W'(slot);
    b.load  = load;
    send_beat(b);
  endtask

  task automatic send_dispatch(input logic critical, input logic [KIND_W-1:0] kind,
                               input logic [LOAD_W-1:0] thermal, input logic hot,
                               input logic eco, input logic throttle);
    task_beat_t b;
    b          = rand_beat(ACT_DISPATCH);
    b.critical = critical;
    b.kind     = kind;
    b.thermal  = thermal;
    b.hot      = hot;
    b.eco      = eco;
    b.throttle = throttle;
    send_beat(b);
  endtask

  // Let every outstanding dispatch finish before registers change.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_decisions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write all four registers on back-to-back cycles.
  task automatic program_regs(input logic [15:0] dev_cnt, input logic [15:0] node_cnt,
                              input logic [15:0] thresh, input logic [15:0] bonus);
    logic [CFG_DATA_W-1:0] vals [4];
    logic [CFG_IDX_W-1:0]  idx  [4];
    vals = '{dev_cnt, node_cnt, thresh, bonus};
    idx  = '{CFG_DEVICE_COUNT, CFG_NODE_COUNT, CFG_THRESHOLD, CFG_BONUS};
    for (int k = 0; k < 4; k++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= vals[k];
      @(posedge clk);
    end
    cfg_we       <= 1'b0;
    dev_cnt_reg  = dev_cnt[CNT_W-1:0];
    node_cnt_reg = node_cnt[CNT_W-1:0];
    thresh_reg   = thresh[LOAD_W-1:0];
    bonus_reg    = bonus[BONUS_W-1:0];
  endtask

  // Out of reset there are no devices and no nodes: every dispatch finds no target.
  task automatic test_empty_tables();
    send_dispatch(1'b0, 2'd3, Q_ONE, 1'b1, 1'b1, 1'b1);
    send_beat(rand_beat(ACT_UNUSED));
    send_dispatch(1'b1, 2'd0, 9'd0, 1'b0, 1'b0, 1'b0);
  endtask

  // Offload choice, tie breaking and every scoring rule on a small hand-built table.
  task automatic test_offload_and_scoring();
    send_device(0, CAT_CPU, 16'hFFFF, 9'd0);
    send_device(1, CAT_GPU, 16'h8000, Q_ONE);
    send_device(2, CAT_NPU, 16'h1234, 9'h1FF);
    send_device(3, CAT_DSP, 16'h4000, 9'd100);
    send_device(4, CAT_TOP, 16'hFFFF, 9'd0);
    // Nodes 1 and 2 tie for the lowest load; node 1 must win.
    send_node(0, 9'd300);
    send_node(1, 9'd200);
    send_node(2, 9'd200);
    wait_idle();
    program_regs(16'd5, 16'd3, 16'd256, 16'd5120);
    send_dispatch(1'b0, 2'd0, Q_ONE, 1'b0, 1'b0, 1'b0);
    // Critical task stays local; CPU and the top category tie and the CPU wins.
    send_dispatch(1'b1, 2'd3, 9'h1FF, 1'b0, 1'b0, 1'b0);
    send_dispatch(1'b1, 2'd1, Q_ONE, 1'b1, 1'b0, 1'b0);
    // A zero threshold never offloads, so scoring runs with eco mode as well.
    wait_idle();
    program_regs(16'd5, 16'd3, 16'd0, 16'hFFFF);
    send_dispatch(1'b0, 2'd0, Q_ONE, 1'b0, 1'b1, 1'b0);
    send_dispatch(1'b1, 2'd3, Q_ONE, 1'b0, 1'b1, 1'b1);
    send_dispatch(1'b1, 2'd1, 9'd128, 1'b0, 1'b0, 1'b1);
    send_dispatch(1'b1, 2'd2, 9'd0, 1'b0, 1'b0, 1'b0);
    send_dispatch(1'b1, 2'd0, Q_ONE, 1'b0, 1'b0, 1'b0);
  endtask

  // Fill every slot, then run phases of random traffic under random register settings.
  task automatic test_random_traffic();
    task_beat_t b;
    for (int i = 0; i < MAX_DEVICES; i++) begin
      b = rand_beat(ACT_DEV);
      b.entry = ENTRY_W'(i);
      send_beat(b);
    end
    for (int i = 0; i < MAX_NODES; i++) begin
      b = rand_beat(ACT_NODE);
      b.entry = ENTRY_W'(i);
      send_beat(b);
    end
    for (int phase = 0; phase < 10; phase++) begin
      wait_idle();
      program_regs(pick_count(), pick_count(), pick_thresh(), pick_bonus());
      // Two phases run with both sides at full rate.
      quiet = (phase == 4 || phase == 5);
      for (int n = 0; n < 70; n++) send_beat(rand_item());
    end
    quiet = 1'b0;
  endtask

  // The receiver holds off for a long stretch while dispatches keep coming.
  task automatic test_backpressure();
    wait_idle();
    program_regs(16'd16, 16'd16, 16'd128, 16'd5120);
    quiet = 1'b1;
    hold_request = HOLD_CYCLES;
    for (int n = 0; n < 16; n++) begin
      if (n % 4 == 3) send_beat(rand_beat(ACT_DEV));
      else send_beat(rand_beat(ACT_DISPATCH));
    end
    quiet = 1'b0;
  endtask

  // Result checker and output-side flow control.
  initial begin : result_check
    decision_t exp_d;
    int        hold_left;
    logic      hold_taken;
    hold_left  = 0;
    hold_taken = 1'b0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
        if (expected_decisions.size() == 0) begin
          $error("result beat with no dispatch pending: decision %0d target %0d",
                 out_decision, out_target_index);
          errors++;
        end else begin
          exp_d = expected_decisions.pop_front();
          if (out_decision !== exp_d.decision) begin
            $error("decision: expected %0d, got %0d", exp_d.decision, out_decision);
            errors++;
          end
          if (out_target_index !== exp_d.target) begin
            $error("target_index: expected %0d, got %0d", exp_d.target, out_target_index);
            errors++;
          end
          if (out_best_score !== exp_d.score) begin
            $error("best_score: expected %0d, got %0d", exp_d.score, out_best_score);
            errors++;
          end
        end
      end
      @(posedge clk);
      if (hold_request > 0 && !hold_taken) begin
        hold_left  = hold_request;
        hold_taken = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= quiet || ($urandom_range(0, 99) >= 16);
      end
    end
  end

  // Watchdog on the total run length.
  initial begin : watchdog
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("FAIL device_dispatch_selector_unit");
        $finish;
      end
    end
  end

  initial begin : stimulus
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_action         = ACT_DEV;
    in_entry_index    = '0;
    in_category       = CAT_CPU;
    in_perf_score     = '0;
    in_entry_load     = '0;
    in_task_critical  = 1'b0;
    in_model_kind     = '0;
    in_thermal_factor = '0;
    in_overheating    = 1'b0;
    in_eco_mode       = 1'b0;
    in_power_throttle = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = CFG_DEVICE_COUNT;
    cfg_data          = '0;
    // Register values after reset; table contents are never read before a write.
    dev_cnt_reg  = '0;
    node_cnt_reg = '0;
    thresh_reg   = THRESH_RST;
    bonus_reg    = BONUS_RST;
    for (int i = 0; i < MAX_DEVICES; i++) begin
      cat_tbl[i]      = '0;
      perf_tbl[i]     = '0;
      dev_load_tbl[i] = '0;
    end
    for (int i = 0; i < MAX_NODES; i++) node_load_tbl[i] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_tables();
    test_offload_and_scoring();
    test_random_traffic();
    test_backpressure();
    wait_idle();
    if (errors == 0) begin
      $display("PASS device_dispatch_selector_unit");
    end else begin
      $display("FAIL device_dispatch_selector_unit");
    end
    $finish;
  end

endmodule

// ===== device_dispatch_selector_unit.f =====
+incdir+design
design/dds_pkg.sv
design/dds_cell.sv
design/dds_ctrl.sv
design/device_dispatch_selector_unit.sv
design/dds_checker.sv
dv/tb_device_dispatch_selector_unit.sv
